@@ hdl/gelf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gelf_pkg;

    localparam int EXPERT_COUNT = 8;
    localparam int IN_MAX       = 64;
    localparam int OUT_MAX      = 16;

    localparam int EXP_W   = 3;
    localparam int INNER_W = 6;
    localparam int COL_W   = 4;
    localparam int ADDR_W  = EXP_W + INNER_W + COL_W;
    localparam int CNT_W   = 7;
    localparam int NOUT_W  = 5;
    localparam int ACC_W   = 48;

    localparam logic CFG_IN_WIDTH  = 1'b0;
    localparam logic CFG_OUT_WIDTH = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [2:0]         expert_id;
        logic [5:0]         inner_index;
        logic [3:0]         column_index;
        logic signed [15:0] weight_value;
        logic signed [15:0] act_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         out_column;
        logic signed [31:0] out_value;
        logic               last_of_row;
    } t_out_item;

    typedef struct packed {
        logic               is_act;
        logic [EXP_W-1:0]   expert;
        logic [ADDR_W-1:0]  addr;
        logic signed [15:0] weight;
        logic signed [15:0] act;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  nin;
        logic [NOUT_W-1:0] nout;
    } t_cfg;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_out;

endpackage
`default_nettype wire

@@ hdl/gelf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gelf_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  gelf_pkg::t_in_item        i_item,
    output gelf_pkg::t_queue_out      o_q,
    input  wire                       i_pop
);
    gelf_pkg::t_cmd r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    gelf_pkg::t_cmd cmd;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;

    always_comb begin
        cmd.is_act = i_item.mode;
        cmd.expert = i_item.expert_id;
        cmd.addr   = {i_item.expert_id, i_item.inner_index, i_item.column_index};
        cmd.weight = i_item.weight_value;
        cmd.act    = i_item.act_value;
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.cmd   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_q.valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_pop) |=> r_cnt == 2'd2)
        else $error("full queue lost an entry");
endmodule
`default_nettype wire

@@ hdl/gelf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gelf_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  gelf_pkg::t_cfg            i_cfg,
    input  gelf_pkg::t_queue_out      i_q,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire                       i_stall,
    output gelf_pkg::t_out_item       o_item
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_mem [gelf_pkg::EXPERT_COUNT * gelf_pkg::IN_MAX * gelf_pkg::OUT_MAX];
    logic signed [15:0] r_rdata;
    logic signed [15:0] r_act, n_act;
    logic [gelf_pkg::EXP_W-1:0] r_row_expert, n_row_expert;
    logic [gelf_pkg::CNT_W-1:0] r_count, n_count;
    logic [gelf_pkg::COL_W-1:0] r_col, n_col;
    logic r_s1_v, r_s2_v;
    logic [gelf_pkg::COL_W-1:0] r_s1_col, r_s2_col;
    logic signed [31:0] r_prod;
    logic signed [gelf_pkg::ACC_W-1:0] r_acc [gelf_pkg::OUT_MAX];
    logic r_out_v;
    gelf_pkg::t_out_item r_out;

    logic rd_en, wr_en, col_last, out_free, emit_ld;
    logic [gelf_pkg::ADDR_W-1:0] rd_addr;
    logic signed [gelf_pkg::ACC_W-1:0] acc_sel;
    logic signed [31:0] sat;

    assign out_free = !r_out_v || !i_stall;
    assign col_last = ({1'b0, r_col} + 5'd1) == i_cfg.nout;
    assign rd_addr  = {r_row_expert, r_count[gelf_pkg::INNER_W-1:0], r_col};
    assign wr_en    = o_pop && !i_q.cmd.is_act;
    assign acc_sel  = r_acc[r_col];
    assign emit_ld  = (r_state == S_EMIT) && out_free;

    always_comb begin
        if (acc_sel[47:31] == 17'h00000 || acc_sel[47:31] == 17'h1FFFF) begin
            sat = acc_sel[31:0];
        end else if (acc_sel[47]) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = 32'sh7FFF_FFFF;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_row_expert = r_row_expert;
        n_count      = r_count;
        n_col        = r_col;
        o_pop        = 1'b0;
        rd_en        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q.valid) begin
                    o_pop = 1'b1;
                    if (i_q.cmd.is_act) begin
                        if (r_count == '0) n_row_expert = i_q.cmd.expert;
                        n_act   = i_q.cmd.act;
                        n_col   = '0;
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                rd_en = 1'b1;
                n_col = r_col + 4'd1;
                if (col_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_col = '0;
                    if ((r_count + 7'd1) >= i_cfg.nin) begin
                        n_count = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_count = r_count + 7'd1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_col = r_col + 4'd1;
                    if (col_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[i_q.cmd.addr] <= i_q.cmd.weight;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 32'(r_act) * 32'(r_rdata);
        if (emit_ld) begin
            r_out.out_column  <= r_col;
            r_out.out_value   <= sat;
            r_out.last_of_row <= col_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_act        <= '0;
            r_row_expert <= '0;
            r_count      <= '0;
            r_col        <= '0;
            r_s1_v       <= 1'b0;
            r_s2_v       <= 1'b0;
            r_s1_col     <= '0;
            r_s2_col     <= '0;
            r_out_v      <= 1'b0;
            for (int i = 0; i < gelf_pkg::OUT_MAX; i++) r_acc[i] <= '0;
        end else begin
            r_state      <= n_state;
            r_act        <= n_act;
            r_row_expert <= n_row_expert;
            r_count      <= n_count;
            r_col        <= n_col;
            r_s1_v       <= rd_en;
            r_s1_col     <= r_col;
            r_s2_v       <= r_s1_v;
            r_s2_col     <= r_s1_col;
            if (r_s2_v) begin
                r_acc[r_s2_col] <= r_acc[r_s2_col] + {{16{r_prod[31]}}, r_prod};
            end
            if (emit_ld) begin
                r_acc[r_col] <= '0;
                r_out_v      <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_s1_v && !r_s2_v))
        else $error("emit while products in flight");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count[6] == 1'b0)
        else $error("element count beyond inner range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |=> (r_s1_v && !o_pop))
        else $error("mac issue lost");
endmodule
`default_nettype wire

@@ hdl/grouped_expert_linear_forward_core.sv @@
// Expert-grouped matrix-vector product.
// Input channel (i_valid / o_stall, payload i_item): mode 0 beats write one
// Q8.8 weight word at {expert, inner index, column}; mode 1 beats carry one
// Q8.8 activation element of a row, the first beat of a row picks the expert.
// Output channel (o_valid / i_stall, payload o_item): at row end one beat per
// column, Q16.16 saturated, the final one flagged last_of_row.
// Config port: i_cfg_we writes i_cfg_data to in_width (0) or out_width (1).
// A two-entry queue decouples input acceptance from the compute sequencer.
// An activation element takes one weight read per column through a single
// memory read port and one shared multiply-accumulate pipeline of three
// stages, plus drain. At row end the results leave at one beat per cycle
// from an output register while the receiver does not stall.
// Reset clears the queue, accumulators, counters and config to 64 / 16; the
// weight memory is not cleared. A stalled receiver holds the output beat; the
// sequencer then waits and the queue fills until o_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module grouped_expert_linear_forward_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  gelf_pkg::t_in_item        i_item,
    output logic                      o_valid,
    input  wire                       i_stall,
    output gelf_pkg::t_out_item       o_item,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_idx,
    input  wire [6:0]                 i_cfg_data
);
    logic [6:0] r_in_width;
    logic [4:0] r_out_width;
    gelf_pkg::t_cfg cfg;
    gelf_pkg::t_queue_out q;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= 7'd64;
            r_out_width <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gelf_pkg::CFG_IN_WIDTH:  r_in_width  <= i_cfg_data;
                gelf_pkg::CFG_OUT_WIDTH: r_out_width <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_in_width == 7'd0) cfg.nin = 7'd1;
        else if (r_in_width > 7'd64) cfg.nin = 7'd64;
        else cfg.nin = r_in_width;
        if (r_out_width == 5'd0) cfg.nout = 5'd1;
        else if (r_out_width > 5'd16) cfg.nout = 5'd16;
        else cfg.nout = r_out_width;
    end

    gelf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_q     (q),
        .i_pop   (pop)
    );

    gelf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_q     (q),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );
endmodule
`default_nettype wire
